[rtl/rate_ratio_window_monitor_assert.svh]
// Assertion macros for the rate ratio window monitor checker.
// Needs nothing else; the checker includes this file by name.
`ifndef RATE_RATIO_WINDOW_MONITOR_ASSERT_SVH
`define RATE_RATIO_WINDOW_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RRWM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rrwm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define RRWM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rrwm: next-cycle check failed");

`endif

[rtl/rrwm_pkg.sv]
// Shared constants and types of the rate ratio window monitor.
// No dependencies; the interfaces, the top level and the checker use it.
package rrwm_pkg;

   // item kinds
   localparam logic [1:0] KIND_SAMPLE    = 2'd0;
   localparam logic [1:0] KIND_CLEAR     = 2'd1;
   localparam logic [1:0] KIND_CLEAR_ALL = 2'd2;
   localparam logic [1:0] KIND_UNUSED    = 2'd3;

   typedef logic [1:0] kind_type;

   // register file layout
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_DETECT_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_WARP     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_REAL_DT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SAMPLES   = 3'd4;

   localparam int WARP_W  = 13;
   localparam int TOL_W   = 10;
   localparam int MAXDT_W = 18;
   localparam int MIN_W   = 7;
   localparam int HELD_W  = 7;   // width of the reported pair count
   localparam int FRAC_W  = 10;  // ratio fixed point: 1/1024 units

   localparam logic [WARP_W-1:0]  WARP_RST   = 13'd1024;
   localparam logic [TOL_W-1:0]   TOL_RST    = 10'd51;
   localparam logic [MAXDT_W-1:0] MAXDT_RST  = 18'd200000;
   localparam logic [MIN_W-1:0]   MIN_RST    = 7'd30;

endpackage

[rtl/rrwm_req_if.sv]
// Sample channel of the rate ratio window monitor: valid/ready plus one word.
// Depends on rrwm_pkg.
interface rrwm_req_if #(parameter int DT_BITS = 18);
   logic                   valid;
   logic                   ready;
   rrwm_pkg::kind_type     kind;
   logic [DT_BITS-1:0]     real_dt_us;
   logic [DT_BITS-1:0]     game_dt_us;
   logic                   paused_or_dead;

   modport source (output valid, kind, real_dt_us, game_dt_us, paused_or_dead,
                   input ready);
   modport sink   (input valid, kind, real_dt_us, game_dt_us, paused_or_dead,
                   output ready);
endinterface

// Result channel: valid/ready plus the flag and the pair count.
interface rrwm_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          speed_mismatch;
   logic [rrwm_pkg::HELD_W-1:0]   samples_held;

   modport source (output valid, speed_mismatch, samples_held, input ready);
   modport sink   (input valid, speed_mismatch, samples_held, output ready);
endinterface

[rtl/rate_ratio_window_monitor.sv]
// Rate ratio window monitor: an accepted word passes stages 1, 2 and 3 and the
// result register; one word per cycle sustained while the result side is ready.
// The ring memory is read at accept and written when the word leaves stage 1,
// so the rate is set by that one read and one write port per cycle.
// Synchronous active-high reset clears pipeline valids, window counters, sums,
// the mismatch flag and the registers to their defaults; the ring needs none.
module rate_ratio_window_monitor #(
   parameter int WINDOW  = 120,
   parameter int DT_BITS = 18
) (
   input  logic                              clock,
   input  logic                              reset,
   rrwm_req_if.sink                          req,
   rrwm_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [rrwm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [rrwm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   localparam int ADDR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int CMP_W   = (CNT_W > rrwm_pkg::MIN_W) ? CNT_W : rrwm_pkg::MIN_W;
   localparam int DTX_W   = (DT_BITS > rrwm_pkg::MAXDT_W) ? DT_BITS : rrwm_pkg::MAXDT_W;
   localparam int SUM_W   = DT_BITS + CNT_W;
   localparam int PROD_W  = SUM_W + rrwm_pkg::WARP_W;

   // Stage 1: decisions made at accept, waiting for the ring read.
   typedef struct packed {
      logic                clr;      // empty the window
      logic                clr_all;  // also drop the flag
      logic                take;     // pair enters the ring
      logic                full;     // oldest pair leaves the sums
      logic                chk;      // ratio is checked after this pair
      logic [CNT_W-1:0]    held;
      logic [ADDR_W-1:0]   pos;
      logic [DT_BITS-1:0]  real_dt;
      logic [DT_BITS-1:0]  game_dt;
   } s1_type;

   // Stages 2 and 3: what the check and the result still need.
   typedef struct packed {
      logic                clr_all;
      logic                chk;
      logic [CNT_W-1:0]    held;
   } flag_type;

   //------------------------------------------------------------------
   // Registers
   //------------------------------------------------------------------
   logic                          detect_en_ff;
   logic [rrwm_pkg::WARP_W-1:0]   time_warp_ff;
   logic [rrwm_pkg::TOL_W-1:0]    tolerance_ff;
   logic [rrwm_pkg::MAXDT_W-1:0]  max_real_dt_ff;
   logic [rrwm_pkg::MIN_W-1:0]    min_samples_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         detect_en_ff   <= 1'b1;
         time_warp_ff   <= rrwm_pkg::WARP_RST;
         tolerance_ff   <= rrwm_pkg::TOL_RST;
         max_real_dt_ff <= rrwm_pkg::MAXDT_RST;
         min_samples_ff <= rrwm_pkg::MIN_RST;
      end else if (csr_we) begin
         case (csr_index)
            rrwm_pkg::CSR_DETECT_ENABLE: detect_en_ff   <= csr_wdata[0];
            rrwm_pkg::CSR_TIME_WARP:     time_warp_ff   <= csr_wdata[rrwm_pkg::WARP_W-1:0];
            rrwm_pkg::CSR_TOLERANCE:     tolerance_ff   <= csr_wdata[rrwm_pkg::TOL_W-1:0];
            rrwm_pkg::CSR_MAX_REAL_DT:   max_real_dt_ff <= csr_wdata[rrwm_pkg::MAXDT_W-1:0];
            rrwm_pkg::CSR_MIN_SAMPLES:   min_samples_ff <= csr_wdata[rrwm_pkg::MIN_W-1:0];
            default: ;
         endcase
      end
   end

   //------------------------------------------------------------------
   // Flow control: the whole pipe moves when the result register is free.
   //------------------------------------------------------------------
   logic pipe_adv;
   logic req_take;
   logic out_valid_ff;

   assign pipe_adv  = !out_valid_ff || rsp.ready;
   assign req.ready = pipe_adv;
   assign req_take  = req.valid && pipe_adv;

   //------------------------------------------------------------------
   // Stage 0: classify the word against the window control state.
   //------------------------------------------------------------------
   logic [ADDR_W-1:0]  pos_ff,    pos_in;
   logic [CNT_W-1:0]   held_ff,   held_in;
   logic               primed_ff, primed_in;
   s1_type             s1_ff,     s1_in;
   logic               s1_valid_ff;

   logic               is_sample;
   logic               sample_live;
   logic               dt_ok;

   always_comb begin
      is_sample   = (req.kind == rrwm_pkg::KIND_SAMPLE);
      sample_live = is_sample && detect_en_ff && !req.paused_or_dead;
      dt_ok       = (DTX_W'(req.real_dt_us) <= DTX_W'(max_real_dt_ff))
                    && (req.real_dt_us != '0) && (req.game_dt_us != '0);

      s1_in.clr_all = (req.kind == rrwm_pkg::KIND_CLEAR_ALL);
      s1_in.clr     = (req.kind == rrwm_pkg::KIND_CLEAR) || s1_in.clr_all
                      || (is_sample && !detect_en_ff);
      s1_in.take    = sample_live && primed_ff && dt_ok;
      s1_in.full    = (held_ff >= CNT_W'(WINDOW));
      s1_in.pos     = pos_ff;
      s1_in.real_dt = req.real_dt_us;
      s1_in.game_dt = req.game_dt_us;

      // advance the counters for this word
      held_in   = held_ff;
      pos_in    = pos_ff;
      primed_in = primed_ff;
      if (s1_in.clr) begin
         held_in   = '0;
         pos_in    = '0;
         primed_in = 1'b0;
      end else if (sample_live && !primed_ff) begin
         primed_in = 1'b1;
      end else if (s1_in.take) begin
         if (!s1_in.full) begin
            held_in = held_ff + CNT_W'(1);
         end
         pos_in = (pos_ff == ADDR_W'(WINDOW - 1)) ? '0 : pos_ff + ADDR_W'(1);
      end

      s1_in.held = held_in;
      s1_in.chk  = s1_in.take && (CMP_W'(held_in) >= CMP_W'(min_samples_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         held_ff     <= '0;
         primed_ff   <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else if (pipe_adv) begin
         s1_valid_ff <= req.valid;
         if (req.valid) begin
            pos_ff    <= pos_in;
            held_ff   <= held_in;
            primed_ff <= primed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_ff <= s1_in;
      end
   end

   //------------------------------------------------------------------
   // Ring memory: {claimed, real} per entry. Read the slot about to be
   // overwritten at accept; write it back when the word leaves stage 1.
   //------------------------------------------------------------------
   logic                    ring_we;
   logic [2*DT_BITS-1:0]    ring_rdata;
   logic [DT_BITS-1:0]      old_real;
   logic [DT_BITS-1:0]      old_game;

   assign ring_we  = pipe_adv && s1_valid_ff && s1_ff.take;
   assign old_real = ring_rdata[DT_BITS-1:0];
   assign old_game = ring_rdata[2*DT_BITS-1:DT_BITS];

   rrwm_ram #(
      .WIDTH (2 * DT_BITS),
      .DEPTH (WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (s1_ff.pos),
      .wr_data ({s1_ff.game_dt, s1_ff.real_dt}),
      .rd_en   (req_take),
      .rd_addr (pos_ff),
      .rd_data (ring_rdata)
   );

   //------------------------------------------------------------------
   // Stage 1: running sums. Drop the oldest pair when the ring is full.
   //------------------------------------------------------------------
   logic [SUM_W-1:0] real_sum_ff, real_sum_in;
   logic [SUM_W-1:0] game_sum_ff, game_sum_in;
   flag_type         s2_ff, s2_in;
   logic             s2_valid_ff;

   always_comb begin
      real_sum_in = real_sum_ff;
      game_sum_in = game_sum_ff;
      if (s1_ff.clr) begin
         real_sum_in = '0;
         game_sum_in = '0;
      end else if (s1_ff.take) begin
         real_sum_in = real_sum_ff + SUM_W'(s1_ff.real_dt)
                       - (s1_ff.full ? SUM_W'(old_real) : SUM_W'(0));
         game_sum_in = game_sum_ff + SUM_W'(s1_ff.game_dt)
                       - (s1_ff.full ? SUM_W'(old_game) : SUM_W'(0));
      end
      s2_in.clr_all = s1_ff.clr_all;
      s2_in.chk     = s1_ff.chk;
      s2_in.held    = s1_ff.held;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         real_sum_ff <= '0;
         game_sum_ff <= '0;
         s2_valid_ff <= 1'b0;
      end else if (pipe_adv) begin
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            real_sum_ff <= real_sum_in;
            game_sum_ff <= game_sum_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   //------------------------------------------------------------------
   // Stage 2: products of the ratio test, taken from the sums that this
   // word left behind (the next word updates them only on the same edge).
   //------------------------------------------------------------------
   logic [PROD_W-1:0] lhs_ff, lhs_in;
   logic [PROD_W-1:0] rhs_ff, rhs_in;
   logic [PROD_W-1:0] tol_ff, tol_in;
   flag_type          s3_ff;
   logic              s3_valid_ff;

   always_comb begin
      lhs_in = PROD_W'({game_sum_ff, {rrwm_pkg::FRAC_W{1'b0}}});
      rhs_in = PROD_W'(time_warp_ff) * PROD_W'(real_sum_ff);
      tol_in = PROD_W'(tolerance_ff) * PROD_W'(real_sum_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (pipe_adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv && s2_valid_ff) begin
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
         tol_ff <= tol_in;
         s3_ff  <= s2_ff;
      end
   end

   //------------------------------------------------------------------
   // Stage 3: compare and update the sticky flag; load the result register.
   //------------------------------------------------------------------
   logic [PROD_W-1:0]           diff;
   logic                        violate;
   logic                        mismatch_ff, mismatch_in;
   logic                        out_mis_ff;
   logic [rrwm_pkg::HELD_W-1:0] out_held_ff;

   always_comb begin
      diff        = (lhs_ff > rhs_ff) ? (lhs_ff - rhs_ff) : (rhs_ff - lhs_ff);
      violate     = s3_ff.chk && (diff > tol_ff);
      mismatch_in = s3_ff.clr_all ? 1'b0 : (mismatch_ff || violate);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mismatch_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (pipe_adv) begin
         out_valid_ff <= s3_valid_ff;
         if (s3_valid_ff) begin
            mismatch_ff <= mismatch_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv && s3_valid_ff) begin
         out_mis_ff  <= mismatch_in;
         out_held_ff <= rrwm_pkg::HELD_W'(s3_ff.held);
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.speed_mismatch = out_mis_ff;
   assign rsp.samples_held   = out_held_ff;
endmodule

[rtl/rrwm_ram.sv]
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module rrwm_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 120
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/rrwm_checker.sv]
// Port-level checker for the rate ratio window monitor, bound to the top.
// Depends on rrwm_pkg and rate_ratio_window_monitor_assert.svh.
`include "rate_ratio_window_monitor_assert.svh"

module rrwm_checker #(
   parameter int WINDOW = 120
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_speed_mismatch,
   input logic [rrwm_pkg::HELD_W-1:0]   rsp_samples_held
);
   // a stalled result word holds its value
   `RRWM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_speed_mismatch) && $stable(rsp_samples_held))

   // a full result register freezes the pipe, so no new word is taken
   `RRWM_ASSERT_IMPLY(a_stall_blocks_req, clock, reset, rsp_valid && !rsp_ready, !req_ready)

   // the reported count never exceeds the window when it fits the field
   `RRWM_ASSERT_IMPLY(a_held_bound, clock, reset, rsp_valid, (WINDOW >= 128) || (rsp_samples_held <= rrwm_pkg::HELD_W'(WINDOW)))

   // an empty or draining result register lets the next word in
   `RRWM_ASSERT_IMPLY(a_ready_when_free, clock, reset, !rsp_valid || rsp_ready, req_ready)
endmodule

bind rate_ratio_window_monitor rrwm_checker #(
   .WINDOW (WINDOW)
) u_rrwm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req.valid),
   .req_ready          (req.ready),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_speed_mismatch (rsp.speed_mismatch),
   .rsp_samples_held   (rsp.samples_held)
);

[dv/rate_ratio_window_monitor_tb.sv]
// Self-checking testbench for rate_ratio_window_monitor: directed and random
// words with a word-level predictor and in-order result checking.
// Depends on rrwm_pkg, rrwm_req_if, rrwm_rsp_if and the monitor RTL.
module rate_ratio_window_monitor_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW        = 120;
   localparam int DT_BITS       = 18;
   localparam int DT_MAX        = (1 << DT_BITS) - 1;
   localparam int SETTLE_CYCLES = 8;        // settle time after the last owed result word
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic                          speed_mismatch;
      logic [rrwm_pkg::HELD_W-1:0]   samples_held;
   } status_word_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_we;
   logic [rrwm_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [rrwm_pkg::CSR_DATA_W-1:0] csr_wdata;

   rrwm_req_if #(.DT_BITS(DT_BITS)) req_ch ();
   rrwm_rsp_if                      rsp_ch ();

   rate_ratio_window_monitor #(
      .WINDOW  (WINDOW),
      .DT_BITS (DT_BITS)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predictor copy of the window, the sums and the register file.
   logic [DT_BITS-1:0]           real_hist [WINDOW];
   logic [DT_BITS-1:0]           game_hist [WINDOW];
   int unsigned                  hist_pos;
   int unsigned                  pairs_held;
   logic [63:0]                  real_total;
   logic [63:0]                  game_total;
   logic                         primed_m;
   logic                         flag_m;
   logic                         cfg_enable;
   logic [rrwm_pkg::WARP_W-1:0]  cfg_warp;
   logic [rrwm_pkg::TOL_W-1:0]   cfg_tol;
   logic [rrwm_pkg::MAXDT_W-1:0] cfg_max_dt;
   logic [rrwm_pkg::MIN_W-1:0]   cfg_min_pairs;

   // Status words still owed by the block, oldest first.
   status_word_type awaited_status[$];

   int          fail_count         = 0;
   int unsigned cycle_count        = 0;
   int          sender_gap_pct     = 0;
   int          receiver_stall_pct = 0;
   int          hold_off_left      = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic void empty_window();
      hist_pos   = 0;
      pairs_held = 0;
      real_total = '0;
      game_total = '0;
      primed_m   = 1'b0;
   endfunction

   // Advance the predictor by one accepted word and return the status it owes.
   function automatic status_word_type predict_status(rrwm_pkg::kind_type k,
                                                      logic [DT_BITS-1:0] real_us,
                                                      logic [DT_BITS-1:0] game_us,
                                                      logic paused);
      status_word_type s;
      logic [63:0]     lhs;
      logic [63:0]     rhs;
      logic [63:0]     diff;
      case (k)
         rrwm_pkg::KIND_CLEAR: begin
            empty_window();
         end
         rrwm_pkg::KIND_CLEAR_ALL: begin
            empty_window();
            flag_m = 1'b0;
         end
         rrwm_pkg::KIND_SAMPLE: begin
            if (!cfg_enable) begin
               empty_window();
            end else if (paused) begin
               // paused or dead player: hold everything, priming included
            end else if (!primed_m) begin
               primed_m = 1'b1;
            end else if (real_us > cfg_max_dt || real_us == 0 || game_us == 0) begin
               // rejected interval: drop it, stay primed
            end else begin
               if (pairs_held >= WINDOW) begin
                  // full window: retire the oldest pair before overwriting it
                  real_total -= real_hist[hist_pos];
                  game_total -= game_hist[hist_pos];
               end else begin
                  pairs_held++;
               end
               real_hist[hist_pos] = real_us;
               game_hist[hist_pos] = game_us;
               real_total += real_us;
               game_total += game_us;
               hist_pos = (hist_pos + 1 >= WINDOW) ? 0 : hist_pos + 1;
               if (pairs_held >= cfg_min_pairs && real_total != 0) begin
                  lhs  = game_total << rrwm_pkg::FRAC_W;
                  rhs  = 64'(cfg_warp) * real_total;
                  diff = (lhs > rhs) ? lhs - rhs : rhs - lhs;
                  if (diff > 64'(cfg_tol) * real_total)
                     flag_m = 1'b1;
               end
            end
         end
         default: begin
            // unused kind code: ignored
         end
      endcase
      s.speed_mismatch = flag_m;
      s.samples_held   = pairs_held[rrwm_pkg::HELD_W-1:0];
      return s;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("%0t ns mismatch: %s got %0d want %0d", $time, what, got, want);
      fail_count++;
   endtask

   // Write one register; call only while the block is idle.
   task automatic write_register(logic [rrwm_pkg::CSR_IDX_W-1:0] idx,
                                 int unsigned value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[rrwm_pkg::CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         rrwm_pkg::CSR_DETECT_ENABLE: cfg_enable    = value[0];
         rrwm_pkg::CSR_TIME_WARP:     cfg_warp      = value[rrwm_pkg::WARP_W-1:0];
         rrwm_pkg::CSR_TOLERANCE:     cfg_tol       = value[rrwm_pkg::TOL_W-1:0];
         rrwm_pkg::CSR_MAX_REAL_DT:   cfg_max_dt    = value[rrwm_pkg::MAXDT_W-1:0];
         rrwm_pkg::CSR_MIN_SAMPLES:   cfg_min_pairs = value[rrwm_pkg::MIN_W-1:0];
         default: ;
      endcase
   endtask

   // Offer one word, with random sender gaps ahead of it, and hold it until
   // the block takes it. Valid stays high on return so back-to-back words
   // need no extra edge.
   task automatic send_word(rrwm_pkg::kind_type k, int unsigned real_us,
                            int unsigned game_us, logic paused);
      @(negedge clock);
      while ($urandom_range(99) < sender_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.kind           <= k;
      req_ch.real_dt_us     <= real_us[DT_BITS-1:0];
      req_ch.game_dt_us     <= game_us[DT_BITS-1:0];
      req_ch.paused_or_dead <= paused;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      awaited_status.insert(awaited_status.size(),
                            predict_status(k, real_us[DT_BITS-1:0],
                                           game_us[DT_BITS-1:0], paused));
   endtask

   // Drop valid, wait for every owed word, then let the pipeline go quiet.
   task automatic drain_and_settle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (awaited_status.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Result side: random stalls, or a forced hold-off counted down here.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Compare each accepted result word with the oldest owed status.
   always @(posedge clock) begin
      status_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (awaited_status.size() == 0) begin
            report_mismatch("result word with nothing owed", rsp_ch.samples_held, -1);
         end else begin
            want = awaited_status[0];
            awaited_status.delete(0);
            if (rsp_ch.speed_mismatch !== want.speed_mismatch)
               report_mismatch("speed_mismatch", rsp_ch.speed_mismatch,
                               want.speed_mismatch);
            if (rsp_ch.samples_held !== want.samples_held)
               report_mismatch("samples_held", rsp_ch.samples_held, want.samples_held);
         end
      end
   end

   // Reset values: priming, pauses, rejects, unused kind and both clears.
   task automatic test_defaults();
      send_word(rrwm_pkg::KIND_SAMPLE, 5000, 5000, 1'b1);     // paused before priming
      send_word(rrwm_pkg::KIND_SAMPLE, 0, 0, 1'b0);           // priming ignores its times
      send_word(rrwm_pkg::KIND_SAMPLE, 5000, 5000, 1'b0);
      send_word(rrwm_pkg::KIND_SAMPLE, 0, 5000, 1'b0);        // zero real time
      send_word(rrwm_pkg::KIND_SAMPLE, 5000, 0, 1'b0);        // zero claimed time
      send_word(rrwm_pkg::KIND_SAMPLE, 200001, 5000, 1'b0);   // just above the real limit
      send_word(rrwm_pkg::KIND_SAMPLE, 200000, DT_MAX, 1'b0); // at the limit, saturated
      send_word(rrwm_pkg::KIND_SAMPLE, 7000, 7000, 1'b1);     // paused once primed
      send_word(rrwm_pkg::KIND_UNUSED, DT_MAX, DT_MAX, 1'b1); // unused kind code
      send_word(rrwm_pkg::KIND_CLEAR, DT_MAX, DT_MAX, 1'b1);
      send_word(rrwm_pkg::KIND_SAMPLE, DT_MAX, DT_MAX, 1'b0); // primes again
      send_word(rrwm_pkg::KIND_CLEAR_ALL, 0, 0, 1'b0);
      drain_and_settle();
   endtask

   // Register extremes: zero tolerance, zero warp, check after every pair,
   // a threshold past the window, and detection turned off.
   task automatic test_register_extremes();
      write_register(rrwm_pkg::CSR_MIN_SAMPLES, 1);
      write_register(rrwm_pkg::CSR_TOLERANCE, 0);
      write_register(rrwm_pkg::CSR_TIME_WARP, 1024);
      write_register(rrwm_pkg::CSR_MAX_REAL_DT, DT_MAX);
      send_word(rrwm_pkg::KIND_SAMPLE, 1000, 1000, 1'b0);
      send_word(rrwm_pkg::KIND_SAMPLE, 1000, 1000, 1'b0);     // exact ratio holds
      send_word(rrwm_pkg::KIND_SAMPLE, DT_MAX, DT_MAX, 1'b0);
      send_word(rrwm_pkg::KIND_SAMPLE, 1000, 1001, 1'b0);     // one count off trips the flag
      send_word(rrwm_pkg::KIND_CLEAR, 0, 0, 1'b0);            // flag survives a window clear
      send_word(rrwm_pkg::KIND_CLEAR_ALL, 0, 0, 1'b0);
      drain_and_settle();

      write_register(rrwm_pkg::CSR_MIN_SAMPLES, 0);
      write_register(rrwm_pkg::CSR_TIME_WARP, 0);
      write_register(rrwm_pkg::CSR_TOLERANCE, 1023);
      send_word(rrwm_pkg::KIND_SAMPLE, 1, 1, 1'b0);
      send_word(rrwm_pkg::KIND_SAMPLE, 1, 1, 1'b0);           // any claim beats a zero warp
      drain_and_settle();

      write_register(rrwm_pkg::CSR_DETECT_ENABLE, 0);
      send_word(rrwm_pkg::KIND_SAMPLE, 3000, 3000, 1'b1);     // disabled: clears, flag kept
      drain_and_settle();

      write_register(rrwm_pkg::CSR_DETECT_ENABLE, 1);
      write_register(rrwm_pkg::CSR_MIN_SAMPLES, 127);
      write_register(rrwm_pkg::CSR_TIME_WARP, 8191);
      write_register(rrwm_pkg::CSR_MAX_REAL_DT, 1);
      send_word(rrwm_pkg::KIND_CLEAR_ALL, 0, 0, 1'b0);
      send_word(rrwm_pkg::KIND_SAMPLE, 1, 1, 1'b0);
      send_word(rrwm_pkg::KIND_SAMPLE, 1, DT_MAX, 1'b0);      // threshold never reached
      send_word(rrwm_pkg::KIND_SAMPLE, 2, 1, 1'b0);           // above a one-microsecond limit
      drain_and_settle();
   endtask

   // Random phases: each picks a register setting, then mostly well-formed
   // sample runs around or off the expected ratio, with some noise words.
   task automatic test_random_traffic(int gap_pct, int stall_pct, int words);
      int unsigned        sent;
      int unsigned        phase_words;
      int unsigned        seg_left;
      int unsigned        noise_pct;
      int unsigned        real_us;
      int unsigned        game_us;
      int unsigned        upper;
      int unsigned        warp_v;
      int unsigned        tol_v;
      int unsigned        max_dt_v;
      int unsigned        min_v;
      int                 target;
      longint unsigned    scaled;
      longint unsigned    dev;
      logic               en_v;
      logic               paused;
      rrwm_pkg::kind_type k;
      sent = 0;
      sender_gap_pct     = gap_pct;
      receiver_stall_pct = stall_pct;
      while (sent < words) begin
         drain_and_settle();
         en_v = ($urandom_range(7) != 0);
         case ($urandom_range(7))
            0:       warp_v = 1;
            1:       warp_v = 4096;
            2:       warp_v = 8191;
            3:       warp_v = 0;
            4, 5:    warp_v = 1024;
            default: warp_v = $urandom_range(1, 4096);
         endcase
         case ($urandom_range(3))
            0:       tol_v = 0;
            1:       tol_v = 1023;
            default: tol_v = $urandom_range(1, 200);
         endcase
         case ($urandom_range(3))
            0:       max_dt_v = 1;
            1:       max_dt_v = DT_MAX;
            default: max_dt_v = $urandom_range(20000, DT_MAX);
         endcase
         case ($urandom_range(5))
            0:       min_v = 0;
            1:       min_v = 120;
            2:       min_v = 127;
            default: min_v = $urandom_range(1, 40);
         endcase
         write_register(rrwm_pkg::CSR_DETECT_ENABLE, 32'(en_v));
         write_register(rrwm_pkg::CSR_TIME_WARP, warp_v);
         write_register(rrwm_pkg::CSR_TOLERANCE, tol_v);
         write_register(rrwm_pkg::CSR_MAX_REAL_DT, max_dt_v);
         write_register(rrwm_pkg::CSR_MIN_SAMPLES, min_v);

         phase_words = en_v ? $urandom_range(60, 220) : $urandom_range(8, 20);
         noise_pct   = $urandom_range(1) ? 0 : 12;
         seg_left    = 0;
         target      = 0;
         if ($urandom_range(1)) begin
            send_word(rrwm_pkg::KIND_CLEAR_ALL, 0, 0, 1'b0);
            sent++;
         end
         for (int i = 0; i < phase_words && sent < words; i++) begin
            // pick a new claimed/real ratio now and then: in or out of tolerance
            if (seg_left == 0) begin
               seg_left = $urandom_range(20, 80);
               if ($urandom_range(99) < 60)
                  target = int'(cfg_warp) + int'($urandom_range(cfg_tol / 2))
                           - int'(cfg_tol / 4);
               else if ($urandom_range(1))
                  target = int'(cfg_warp) + int'(cfg_tol) + int'($urandom_range(20, 400));
               else
                  target = int'(cfg_warp) - int'(cfg_tol) - int'($urandom_range(20, 400));
               if (target < 0)
                  target = 0;
            end
            seg_left--;
            if ($urandom_range(99) < noise_pct) begin
               k       = ($urandom_range(3) == 0)
                         ? rrwm_pkg::kind_type'($urandom_range(3))
                         : rrwm_pkg::KIND_SAMPLE;
               real_us = $urandom & DT_MAX;
               game_us = $urandom & DT_MAX;
               paused  = 1'($urandom_range(1));
               send_word(k, real_us, game_us, paused);
               if (k <= rrwm_pkg::KIND_CLEAR_ALL
                   && !(k == rrwm_pkg::KIND_SAMPLE && paused))
                  sent++;
            end else begin
               upper   = (cfg_max_dt < 70000) ? cfg_max_dt : 70000;
               if (upper == 0)
                  upper = 1;
               real_us = $urandom_range(1, upper);
               if ($urandom_range(99) < 3)
                  real_us = (cfg_max_dt == DT_MAX) ? 0 : cfg_max_dt + 1;
               scaled = (longint'(real_us) * longint'(target)) >> rrwm_pkg::FRAC_W;
               dev    = scaled >> 7;
               scaled = scaled + $urandom_range(32'(2 * dev)) - dev;   // small jitter
               if (scaled > DT_MAX)
                  scaled = DT_MAX;
               if (scaled == 0)
                  scaled = 1;
               paused = ($urandom_range(99) < 4);
               send_word(rrwm_pkg::KIND_SAMPLE, real_us, 32'(scaled), paused);
               if (!paused)
                  sent++;
            end
         end
      end
   endtask

   // Hold the result side off for a long stretch while words keep coming,
   // so the block fills and drops its ready.
   task automatic test_backpressure();
      drain_and_settle();
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      write_register(rrwm_pkg::CSR_MIN_SAMPLES, 1);
      write_register(rrwm_pkg::CSR_TIME_WARP, 1024);
      write_register(rrwm_pkg::CSR_TOLERANCE, 51);
      write_register(rrwm_pkg::CSR_MAX_REAL_DT, 200000);
      hold_off_left = 300;
      send_word(rrwm_pkg::KIND_CLEAR_ALL, 0, 0, 1'b0);
      for (int i = 0; i < 60; i++)
         send_word(rrwm_pkg::KIND_SAMPLE, 16000 + $urandom_range(500),
                   (i < 40) ? 16000 : 19000 + $urandom_range(500), 1'b0);
   endtask

   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_ch.valid          = 1'b0;
      req_ch.kind           = rrwm_pkg::KIND_SAMPLE;
      req_ch.real_dt_us     = '0;
      req_ch.game_dt_us     = '0;
      req_ch.paused_or_dead = 1'b0;

      // predictor state after reset
      empty_window();
      flag_m        = 1'b0;
      cfg_enable    = 1'b1;
      cfg_warp      = rrwm_pkg::WARP_RST;
      cfg_tol       = rrwm_pkg::TOL_RST;
      cfg_max_dt    = rrwm_pkg::MAXDT_RST;
      cfg_min_pairs = rrwm_pkg::MIN_RST;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_defaults();
      test_register_extremes();
      test_random_traffic(6, 75, 400);
      test_random_traffic(75, 6, 400);
      test_random_traffic(0, 0, 400);
      test_backpressure();
      drain_and_settle();

      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
